### rtl/sprc_pkg.sv
package sprc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYNC_FIRST      = 3'd0;
    localparam logic [2:0] CFG_SYNC_SECOND     = 3'd1;
    localparam logic [2:0] CFG_MESSAGE_KIND    = 3'd2;
    localparam logic [2:0] CFG_REPORT_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_STALE_LIMIT     = 3'd4;

    // Register reset values.
    localparam logic [31:0] DEFAULT_INTERVAL = 32'd20000;
    localparam logic [31:0] DEFAULT_STALE    = 32'd100000;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // Action codes of an input request.
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Byte positions within the frame header and within one channel record.
    localparam logic [2:0] HDR_LAST   = 3'd7;
    localparam logic [2:0] HDR_KIND   = 3'd6;
    localparam logic [2:0] REC_LAST   = 3'd5;

    typedef struct packed {
        logic        action;
        logic [1:0]  channel;
        logic [31:0] pulse_count;
        logic [31:0] now_us;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_out;

    // One channel entry of the measurement memory.
    typedef struct packed {
        logic [31:0] sample_time;
        logic [15:0] width;
        logic [15:0] period;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAS,
        S_HEAD,
        S_READ,
        S_LOAD,
        S_CHAN,
        S_SUM
    } t_state;

    // Saturate a 32-bit count to 16 bits.
    function automatic logic [15:0] sat16(input logic [31:0] v);
        logic [15:0] r;
        r = (v > {16'd0, SAT16}) ? SAT16 : v[15:0];
        return r;
    endfunction

endpackage

### rtl/servo_pulse_capture_reporter_unit.sv
// Servo pulse capture reporter.
// Input channel (i_valid / o_ready / i_data): a request is either a pulse
// measurement for one channel or a time tick. For a measurement the channel
// entry is first read from the measurement memory, then updated and
// written back. A tick is decided in the cycle it is accepted; when the report
// interval has elapsed it starts a frame, otherwise it leaves no result.
// Output channel (o_valid / i_ready / o_data): one frame byte per request,
// frame_end marks the checksum byte. A frame has 9 + 6*CHANNELS bytes; each
// channel passes a memory read state and a staleness check state before its
// six bytes, which go out one a cycle while the receiver does not stall.
// The first byte is loaded into the output register from the header state.
// Only one request is in work at a time; o_ready is high while the sequencer is
// idle, also while the last frame byte still waits in the output register.
// A stalled receiver holds the output register and the frame sequencer waits.
// Reset is synchronous: configuration returns to its defaults, all channels are
// marked unseen and the last report time is zero; there is no clearing pass.
// Configuration writes take effect at once and must come while idle.
module servo_pulse_capture_reporter_unit #(
    parameter int CHANNELS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sprc_pkg::t_in       i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sprc_pkg::t_out      o_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [31:0] PLEN = 32'(2 + 6 * CHANNELS);
    localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

    // Control and configuration registers.
    sprc_pkg::t_state       r_state, n_state;
    logic [CHANNELS-1:0]    r_seen, n_seen;
    logic [31:0]            r_last_report, n_last_report;
    logic [7:0]             r_sync1, r_sync2, r_kind;
    logic [31:0]            r_interval, r_stale;
    logic                   r_out_valid, n_out_valid;

    // Payload registers.
    sprc_pkg::t_out         r_out, n_out;
    logic [CW-1:0]          r_addr, n_addr;
    logic [CW-1:0]          r_chan, n_chan;
    logic [2:0]             r_cnt, n_cnt;
    logic [15:0]            r_pulse, n_pulse;
    logic [31:0]            r_now, n_now;
    logic [7:0]             r_csum, n_csum;
    logic                   r_cv, n_cv;
    logic [15:0]            r_cpw, n_cpw;
    logic [15:0]            r_cpp, n_cpp;

    // Measurement memory.
    sprc_pkg::t_entry       mem [0:CHANNELS-1];
    sprc_pkg::t_entry       r_rd;
    logic                   rd_en;
    logic [CW-1:0]          rd_addr;
    logic                   mem_we;
    sprc_pkg::t_entry       wdata;

    logic [31:0]            ch_ext;
    logic                   ch_in_range;
    logic                   report_due;
    logic                   can_load;

    assign ch_ext      = 32'(i_data.channel);
    assign ch_in_range = ch_ext < 32'(CHANNELS);
    assign report_due  = (i_data.now_us - r_last_report) >= r_interval;
    assign can_load    = !r_out_valid || i_ready;
    assign o_ready     = (r_state == sprc_pkg::S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // Synchronous memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= wdata;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Sequencer: next state, memory access and frame bytes.
    always_comb begin
        logic       emit;
        logic [7:0] byte_v;
        logic       end_v;
        logic [31:0] age;
        logic       vld;

        n_state       = r_state;
        n_seen        = r_seen;
        n_last_report = r_last_report;
        n_out_valid   = r_out_valid && !i_ready;
        n_out         = r_out;
        n_addr        = r_addr;
        n_chan        = r_chan;
        n_cnt         = r_cnt;
        n_pulse       = r_pulse;
        n_now         = r_now;
        n_csum        = r_csum;
        n_cv          = r_cv;
        n_cpw         = r_cpw;
        n_cpp         = r_cpp;
        rd_en         = 1'b0;
        rd_addr       = r_chan;
        mem_we        = 1'b0;
        wdata         = '0;
        emit          = 1'b0;
        byte_v        = 8'd0;
        end_v         = 1'b0;
        age           = r_now - r_rd.sample_time;
        vld           = 1'b0;

        case (r_state)
            sprc_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_data.action == sprc_pkg::ACT_MEASURE) begin
                        if (ch_in_range) begin
                            rd_en   = 1'b1;
                            rd_addr = ch_ext[CW-1:0];
                            n_addr  = ch_ext[CW-1:0];
                            n_pulse = sprc_pkg::sat16(i_data.pulse_count);
                            n_now   = i_data.now_us;
                            n_state = sprc_pkg::S_MEAS;
                        end
                    end else if (report_due) begin
                        n_last_report = i_data.now_us;
                        n_now         = i_data.now_us;
                        n_cnt         = 3'd0;
                        n_csum        = 8'd0;
                        n_state       = sprc_pkg::S_HEAD;
                    end
                end
            end
            sprc_pkg::S_MEAS: begin
                // Update the entry read in the previous cycle.
                mem_we             = 1'b1;
                wdata.sample_time  = r_now;
                wdata.width        = r_pulse;
                wdata.period       = r_seen[r_addr] ? sprc_pkg::sat16(age) : 16'd0;
                n_seen[r_addr]     = 1'b1;
                n_state            = sprc_pkg::S_IDLE;
            end
            sprc_pkg::S_HEAD: begin
                emit = can_load;
                case (r_cnt)
                    3'd0:    byte_v = r_sync1;
                    3'd1:    byte_v = r_sync2;
                    3'd2:    byte_v = PLEN[7:0];
                    3'd3:    byte_v = PLEN[15:8];
                    3'd4:    byte_v = PLEN[23:16];
                    3'd5:    byte_v = PLEN[31:24];
                    3'd6:    byte_v = r_kind;
                    default: byte_v = 8'(CHANNELS);
                endcase
                if (can_load) begin
                    if (r_cnt >= sprc_pkg::HDR_KIND) begin
                        n_csum = r_csum ^ byte_v;
                    end
                    if (r_cnt == sprc_pkg::HDR_LAST) begin
                        n_cnt   = 3'd0;
                        n_chan  = '0;
                        n_state = sprc_pkg::S_READ;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            sprc_pkg::S_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_chan;
                n_state = sprc_pkg::S_LOAD;
            end
            sprc_pkg::S_LOAD: begin
                // A channel is valid when seen and its last sample is fresh.
                vld     = r_seen[r_chan] && (age <= r_stale);
                n_cv    = vld;
                n_cpw   = vld ? r_rd.width : 16'd0;
                n_cpp   = vld ? r_rd.period : 16'd0;
                n_cnt   = 3'd0;
                n_state = sprc_pkg::S_CHAN;
            end
            sprc_pkg::S_CHAN: begin
                emit = can_load;
                case (r_cnt)
                    3'd0:    byte_v = 8'(r_chan);
                    3'd1:    byte_v = {7'd0, r_cv};
                    3'd2:    byte_v = r_cpw[7:0];
                    3'd3:    byte_v = r_cpw[15:8];
                    3'd4:    byte_v = r_cpp[7:0];
                    default: byte_v = r_cpp[15:8];
                endcase
                if (can_load) begin
                    n_csum = r_csum ^ byte_v;
                    if (r_cnt == sprc_pkg::REC_LAST) begin
                        n_cnt = 3'd0;
                        if (r_chan == LAST_CH) begin
                            n_state = sprc_pkg::S_SUM;
                        end else begin
                            n_chan  = r_chan + 1'b1;
                            n_state = sprc_pkg::S_READ;
                        end
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            sprc_pkg::S_SUM: begin
                emit   = can_load;
                byte_v = r_csum;
                end_v  = 1'b1;
                if (can_load) begin
                    n_state = sprc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sprc_pkg::S_IDLE;
            end
        endcase

        // Load the output register with the next frame byte.
        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.frame_byte = byte_v;
            n_out.frame_end  = end_v;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sprc_pkg::S_IDLE;
            r_seen        <= '0;
            r_last_report <= 32'd0;
            r_out_valid   <= 1'b0;
            r_sync1       <= 8'd0;
            r_sync2       <= 8'd0;
            r_kind        <= 8'd0;
            r_interval    <= sprc_pkg::DEFAULT_INTERVAL;
            r_stale       <= sprc_pkg::DEFAULT_STALE;
        end else begin
            r_state       <= n_state;
            r_seen        <= n_seen;
            r_last_report <= n_last_report;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sprc_pkg::CFG_SYNC_FIRST:      r_sync1    <= i_cfg_data[7:0];
                    sprc_pkg::CFG_SYNC_SECOND:     r_sync2    <= i_cfg_data[7:0];
                    sprc_pkg::CFG_MESSAGE_KIND:    r_kind     <= i_cfg_data[7:0];
                    sprc_pkg::CFG_REPORT_INTERVAL: r_interval <= i_cfg_data;
                    sprc_pkg::CFG_STALE_LIMIT:     r_stale    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_addr  <= n_addr;
        r_chan  <= n_chan;
        r_cnt   <= n_cnt;
        r_pulse <= n_pulse;
        r_now   <= n_now;
        r_csum  <= n_csum;
        r_cv    <= n_cv;
        r_cpw   <= n_cpw;
        r_cpp   <= n_cpp;
    end

    // A due tick starts the frame header at its first byte.
    a_tick_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.action == sprc_pkg::ACT_TICK && report_due)
        |=> (r_state == sprc_pkg::S_HEAD && r_cnt == 3'd0))
        else $error("due tick did not start a frame");

    // An in-range measurement goes to the write-back cycle.
    a_meas_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.action == sprc_pkg::ACT_MEASURE && ch_in_range)
        |=> (r_state == sprc_pkg::S_MEAS && r_addr == $past(ch_ext[CW-1:0])))
        else $error("measurement did not reach write-back");

    // The checksum is sent only after the last channel record.
    a_sum_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sprc_pkg::S_SUM) |-> (r_chan == LAST_CH))
        else $error("checksum before last channel");

    // The channel record counter never passes the last record byte.
    a_rec_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sprc_pkg::S_CHAN) |-> (r_cnt <= sprc_pkg::REC_LAST))
        else $error("channel record counter out of range");

endmodule
